>>> design/brx_pkg.sv
`timescale 1ns / 1ps

package brx_pkg;

    localparam int WORD_W    = 32;
    localparam int SEED_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int IDX_W     = $clog2(NUM_WORDS);
    localparam int ROT_K     = 11;
    localparam int SHL_K     = 9;

    localparam logic [SEED_W-1:0] SEED_RESET = 64'd1;
    localparam logic [SEED_W-1:0] SM_GAMMA   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SEED_W-1:0] SM_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [SEED_W-1:0] SM_MUL_B   = 64'h94D0_49BB_1331_11EB;

    // Item handed from the front queue to the back end.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] bound;
    } item_t;

    // Remainder unit handshake.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } div_rsp_t;

endpackage

>>> design/brx_front.sv
`timescale 1ns / 1ps

module brx_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [brx_pkg::WORD_W-1:0]     bound,
    output brx_pkg::item_t                 head,
    input  logic                           take
);

    logic [brx_pkg::WORD_W-1:0] slot_reg [2];
    logic                       wr_ptr_reg;
    logic                       wr_ptr_next;
    logic                       rd_ptr_reg;
    logic                       rd_ptr_next;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       do_push;
    logic                       do_take;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.bound = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_take;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= bound;
        end
    end

endmodule

>>> design/brx_mod.sv
`timescale 1ns / 1ps

// Restoring remainder, one quotient bit per cycle.
module brx_mod
(
    input  logic              clk,
    input  logic              rst_n,
    input  brx_pkg::div_req_t req,
    output brx_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(brx_pkg::WORD_W);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [brx_pkg::WORD_W-1:0]   rem_reg;
    logic [brx_pkg::WORD_W-1:0]   rem_next;
    logic [brx_pkg::WORD_W-1:0]   dvd_reg;
    logic [brx_pkg::WORD_W-1:0]   dvd_next;
    logic [brx_pkg::WORD_W-1:0]   dsr_reg;
    logic [brx_pkg::WORD_W-1:0]   dsr_next;
    logic [brx_pkg::WORD_W:0]     trial;
    logic [brx_pkg::WORD_W:0]     diff;

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[brx_pkg::WORD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // Subtract when the partial remainder covers the divisor.
            rem_next = diff[brx_pkg::WORD_W] ? trial[brx_pkg::WORD_W-1:0]
                                             : diff[brx_pkg::WORD_W-1:0];
            dvd_next = {dvd_reg[brx_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(brx_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

endmodule

>>> design/brx_back.sv
`timescale 1ns / 1ps

module brx_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seed_we,
    input  logic [brx_pkg::SEED_W-1:0]    seed_data,
    input  brx_pkg::item_t                head,
    output logic                          take,
    output brx_pkg::div_req_t             div_req,
    input  brx_pkg::div_rsp_t             div_rsp,
    output logic                          empty,
    input  logic                          pop,
    output logic [brx_pkg::WORD_W-1:0]    value
);

    localparam int W  = brx_pkg::WORD_W;
    localparam int SW = brx_pkg::SEED_W;

    typedef enum logic [3:0] {
        S_SM_ADD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_IDLE,
        S_DRAW,
        S_MUL,
        S_CHECK,
        S_MOD,
        S_DONE
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [W-1:0]                word_reg [brx_pkg::NUM_WORDS];
    logic [W-1:0]                word_next [brx_pkg::NUM_WORDS];
    logic [brx_pkg::IDX_W-1:0]   idx_reg;
    logic [brx_pkg::IDX_W-1:0]   idx_next;
    logic                        sel_reg;
    logic                        sel_next;
    logic [SW-1:0]               st_reg;
    logic [SW-1:0]               st_next;
    logic [SW-1:0]               z_reg;
    logic [SW-1:0]               z_next;
    logic [SW-1:0]               acc_reg;
    logic [SW-1:0]               acc_next;
    logic [2*W-1:0]              prod_reg;
    logic [2*W-1:0]              prod_next;
    logic [W-1:0]                raw_reg;
    logic [W-1:0]                raw_next;
    logic [W-1:0]                bound_reg;
    logic [W-1:0]                bound_next;
    logic [W-1:0]                thr_reg;
    logic [W-1:0]                thr_next;
    logic                        thr_ok_reg;
    logic                        thr_ok_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [W-1:0]                out_value_reg;
    logic [W-1:0]                out_value_next;
    logic                        start_reg;
    logic                        start_next;

    logic [W-1:0]                mul_a;
    logic [W-1:0]                mul_b;
    logic [SW-1:0]               sm_const;
    logic [SW-1:0]               sm_sum;
    logic [SW-1:0]               mul_res;
    logic [W-1:0]                shl_t;
    logic [W-1:0]                x0;
    logic [W-1:0]                x1;
    logic [W-1:0]                x2;
    logic [W-1:0]                x3;
    logic                        state_zero;
    logic [W-1:0]                low;

    assign empty = !out_valid_reg;
    assign value = out_value_reg;
    assign take  = (state_reg == S_IDLE) && head.valid;

    assign div_req.start    = start_reg;
    assign div_req.dividend = W'(0) - bound_reg;
    assign div_req.divisor  = bound_reg;

    assign sm_const   = sel_reg ? brx_pkg::SM_MUL_B : brx_pkg::SM_MUL_A;
    assign sm_sum     = st_reg + brx_pkg::SM_GAMMA;
    assign mul_res    = {acc_reg[SW-1:W] + prod_reg[W-1:0], acc_reg[W-1:0]};
    assign low        = prod_reg[W-1:0];
    assign state_zero = (word_reg[0] | word_reg[1] | word_reg[2] | word_reg[3]) == '0;

    // One shared 32x32 multiplier; operands follow the state.
    always_comb
    begin
        unique case (state_reg)
            S_MUL0:  begin mul_a = z_reg[W-1:0];  mul_b = sm_const[W-1:0];  end
            S_MUL1:  begin mul_a = z_reg[W-1:0];  mul_b = sm_const[SW-1:W]; end
            S_MUL2:  begin mul_a = z_reg[SW-1:W]; mul_b = sm_const[W-1:0];  end
            S_MUL:   begin mul_a = raw_reg;       mul_b = bound_reg;        end
            default: begin mul_a = '0;            mul_b = '0;               end
        endcase
    end

    // Hold the product outside the multiply states; the check and the
    // result register read it later.
    assign prod_next = (state_reg inside {S_MUL0, S_MUL1, S_MUL2, S_MUL})
                       ? mul_a * mul_b : prod_reg;

    // Generator step.
    always_comb
    begin
        shl_t = word_reg[1] << brx_pkg::SHL_K;
        x2    = word_reg[2] ^ word_reg[0];
        x3    = word_reg[3] ^ word_reg[1];
        x1    = word_reg[1] ^ x2;
        x0    = word_reg[0] ^ x3;
        x2    = x2 ^ shl_t;
        x3    = {x3[W-1-brx_pkg::ROT_K:0], x3[W-1:W-brx_pkg::ROT_K]};
    end

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        st_next        = st_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        raw_next       = raw_reg;
        bound_next     = bound_reg;
        thr_next       = thr_reg;
        thr_ok_next    = thr_ok_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !pop;
        start_next     = 1'b0;

        unique case (state_reg)
            S_SM_ADD:
            begin
                st_next    = sm_sum;
                z_next     = sm_sum ^ (sm_sum >> 30);
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = prod_reg;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next[SW-1:W] = acc_reg[SW-1:W] + prod_reg[W-1:0];
                state_next       = S_MUL3;
            end
            S_MUL3:
            begin
                if (!sel_reg)
                begin
                    z_next     = mul_res ^ (mul_res >> 27);
                    sel_next   = 1'b1;
                    state_next = S_MUL0;
                end
                else
                begin
                    word_next[idx_reg] = mul_res[W-1:0] ^ mul_res[W+30:31];
                    sel_next           = 1'b0;
                    idx_next           = idx_reg + 1'b1;
                    state_next = (idx_reg == brx_pkg::IDX_W'(brx_pkg::NUM_WORDS - 1))
                                 ? S_IDLE : S_SM_ADD;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    bound_next  = head.bound;
                    thr_ok_next = 1'b0;
                    state_next  = S_DRAW;
                end
            end
            S_DRAW:
            begin
                raw_next     = word_reg[0] + word_reg[3];
                word_next[0] = x0;
                word_next[1] = x1;
                word_next[2] = x2;
                word_next[3] = x3;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!thr_ok_reg)
                begin
                    if (low < bound_reg)
                    begin
                        start_next = 1'b1;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if ((low < thr_reg) && !state_zero)
                begin
                    state_next = S_DRAW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    thr_next    = div_rsp.rem;
                    thr_ok_next = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_value_next = prod_reg[2*W-1:W];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Reseed restarts the expansion.
        if (seed_we)
        begin
            st_next    = seed_data;
            idx_next   = '0;
            sel_next   = 1'b0;
            state_next = S_SM_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SM_ADD;
            idx_reg       <= '0;
            sel_reg       <= 1'b0;
            st_reg        <= brx_pkg::SEED_RESET;
            thr_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            for (int i = 0; i < brx_pkg::NUM_WORDS; i++)
            begin
                word_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sel_reg       <= sel_next;
            st_reg        <= st_next;
            thr_ok_reg    <= thr_ok_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            word_reg      <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        raw_reg       <= raw_next;
        bound_reg     <= bound_next;
        thr_reg       <= thr_next;
        out_value_reg <= out_value_next;
    end

endmodule

>>> design/bounded_random_xoshiro128p_top.sv
`timescale 1ns / 1ps

// Bounded uniform random source: each item pushed carries a 32-bit bound and
// yields one item with a value uniform in [0, bound); a bound of zero yields 0.
// Input channel: push/full with bound. Result channel: empty/pop with value;
// the oldest result sits on value while empty is low.
// Seed port: seed_we/seed_data writes the 64-bit seed and restarts the
// expansion of the four generator words; write it only while the block idles.
// Each item runs draw, multiply and compare; when the first product's low
// word is not below the bound, the result goes to the result register;
// otherwise the bit-serial remainder unit (32 steps) forms the rejection
// threshold, and each redraw repeats draw, multiply and compare.
// The threshold is computed at most once per item. Items are worked one at
// a time: the back end takes no new item until it has handed the last one
// to the result register.
// Reset, and each seed write, runs the seed expansion of the four generator
// words on the shared 32x32 multiplier; items pushed meanwhile queue up and
// start once it finishes.
// A two-entry input queue decouples the pusher from the back end, and a
// one-entry result register decouples the back end from the popper: when
// the result is not popped, the back end finishes the next item and holds it
// until the register frees; full rises once both input entries are taken.
module bounded_random_xoshiro128p_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [brx_pkg::WORD_W-1:0]    bound,
    output logic                          empty,
    input  logic                          pop,
    output logic [brx_pkg::WORD_W-1:0]    value,
    input  logic                          seed_we,
    input  logic [brx_pkg::SEED_W-1:0]    seed_data
);

    brx_pkg::item_t    head;
    logic              take;
    brx_pkg::div_req_t div_req;
    brx_pkg::div_rsp_t div_rsp;

    // Front: queue incoming bounds.
    brx_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .bound (bound),
        .head  (head),
        .take  (take)
    );

    // Threshold remainder, shared by every item.
    brx_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: generator, multiply, rejection and result register.
    brx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .head      (head),
        .take      (take),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .empty     (empty),
        .pop       (pop),
        .value     (value)
    );

endmodule

>>> design/brx_checker.sv
`timescale 1ns / 1ps

module brx_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [brx_pkg::WORD_W-1:0]    value
);

    // Items accepted but not yet popped: two queued, one in work, one held.
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc   = push && !full;
    assign out_acc  = pop && !empty;
    assign cnt_next = cnt_reg + {2'b0, in_acc} - {2'b0, out_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value)))
        else $error("result changed or vanished while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cnt_reg != 3'd0))
        else $error("result shown with no item outstanding");

    a_full_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (cnt_reg >= 3'd2))
        else $error("full raised without queued items");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("more items outstanding than storage holds");

endmodule

bind bounded_random_xoshiro128p_top brx_checker u_brx_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .value (value)
);

>>> test/bounded_value_checker.sv
`timescale 1ns / 1ps

module bounded_value_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [brx_pkg::WORD_W-1:0] bound,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [brx_pkg::WORD_W-1:0] value,
    input  logic                       seed_we,
    input  logic [brx_pkg::SEED_W-1:0] seed_data,
    output int unsigned                error_count,
    output int unsigned                outstanding
);

    localparam logic [63:0] RESET_SEED   = 64'd1;
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_1    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_2    = 64'h94D0_49BB_1331_11EB;
    localparam int          MAX_REPORTS  = 10;

    typedef struct packed {
        logic [31:0] bound;
        logic [31:0] value;
    } draw_t;

    logic [31:0] xs_word [4];
    draw_t       expected_draws [$];

    function automatic logic [63:0] mix64(input logic [63:0] st);
        logic [63:0] z;
        z = st;
        z = (z ^ (z >> 30)) * MIX_MUL_1;
        z = (z ^ (z >> 27)) * MIX_MUL_2;
        return z ^ (z >> 31);
    endfunction

    // Expand a seed into the four generator words.
    task automatic reseed(input logic [63:0] s);
        logic [63:0] st;
        logic [63:0] z;
        st = s;
        for (int i = 0; i < 4; i++)
        begin
            st = st + GOLDEN_GAMMA;
            z = mix64(st);
            xs_word[i] = z[31:0];
        end
    endtask

    // One xoshiro128+ step.
    task automatic next_raw(output logic [31:0] raw);
        logic [31:0] t;
        raw = xs_word[0] + xs_word[3];
        t = xs_word[1] << 9;
        xs_word[2] = xs_word[2] ^ xs_word[0];
        xs_word[3] = xs_word[3] ^ xs_word[1];
        xs_word[1] = xs_word[1] ^ xs_word[2];
        xs_word[0] = xs_word[0] ^ xs_word[3];
        xs_word[2] = xs_word[2] ^ t;
        xs_word[3] = {xs_word[3][20:0], xs_word[3][31:21]};
    endtask

    // Draw below the bound, redrawing while the low word falls under the threshold.
    task automatic predict_value(input logic [31:0] b, output logic [31:0] v);
        logic [31:0] raw;
        logic [63:0] prod;
        logic [31:0] thr;
        next_raw(raw);
        prod = {32'd0, raw} * {32'd0, b};
        if (prod[31:0] < b)
        begin
            thr = (32'd0 - b) % b;
            while (prod[31:0] < thr &&
                   (xs_word[0] | xs_word[1] | xs_word[2] | xs_word[3]) != 32'd0)
            begin
                next_raw(raw);
                prod = {32'd0, raw} * {32'd0, b};
            end
        end
        v = prod[63:32];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_t exp_draw;
        logic [31:0] v;
        if (!rst_n)
        begin
            reseed(RESET_SEED);
            expected_draws.delete();
            error_count = 0;
        end
        else
        begin
            if (seed_we)
                reseed(seed_data);
            // Check the popped item before adding this cycle's prediction.
            if (pop && !empty)
            begin
                if (expected_draws.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected item: value %h", value);
                    error_count++;
                end
                else
                begin
                    exp_draw = expected_draws.pop_front();
                    if (value !== exp_draw.value)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display("value mismatch: bound %h expected %h got %h",
                                     exp_draw.bound, exp_draw.value, value);
                        error_count++;
                    end
                end
            end
            if (push && !full)
            begin
                predict_value(bound, v);
                exp_draw.bound = bound;
                exp_draw.value = v;
                expected_draws.push_back(exp_draw);
            end
        end
        outstanding = expected_draws.size();
    end

endmodule

>>> test/bounded_random_xoshiro128p_top_tb.sv
`timescale 1ns / 1ps

module bounded_random_xoshiro128p_top_tb;

    localparam int PHASE_ITEMS = 150;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic [brx_pkg::WORD_W-1:0] bound     = '0;
    logic                       pop       = 1'b0;
    logic                       seed_we   = 1'b0;
    logic [brx_pkg::SEED_W-1:0] seed_data = '0;
    logic                       full;
    logic                       empty;
    logic [brx_pkg::WORD_W-1:0] value;
    int unsigned                error_count;
    int unsigned                outstanding;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bounded_random_xoshiro128p_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bound     (bound),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .seed_we   (seed_we),
        .seed_data (seed_data)
    );

    bounded_value_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .bound       (bound),
        .empty       (empty),
        .pop         (pop),
        .value       (value),
        .seed_we     (seed_we),
        .seed_data   (seed_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Offer one item and hold it until the block takes it. full is read right
    // after the edge, so it still shows the value the edge saw.
    task automatic offer_item(input logic [brx_pkg::WORD_W-1:0] b);
        push  <= 1'b1;
        bound <= b;
        do @(posedge clk); while (full);
    endtask

    // Drop push and put noise on the idle bound while the sender pauses (n >= 1).
    task automatic pause_sender(input int n);
        push  <= 1'b0;
        bound <= $urandom();
        repeat (n) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted item has been popped.
    // Poll on the falling edge so the checker's count is settled.
    task automatic drain_block();
        push <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // Reseed only once the block is idle; it restarts its seed expansion.
    task automatic write_seed(input logic [brx_pkg::SEED_W-1:0] s);
        drain_block();
        seed_we   <= 1'b1;
        seed_data <= s;
        @(posedge clk);
        seed_we   <= 1'b0;
    endtask

    // Mix of bounds: zero, tiny, rejection-heavy just above 2^31, near the top,
    // and fully random words so every bit toggles.
    function automatic logic [brx_pkg::WORD_W-1:0] pick_bound();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(1, 16);
            2:       return 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            4:       return $urandom_range(2, 1000);
            default: return $urandom();
        endcase
    endfunction

    // Bursts of random length; gaps short, medium or none so that idle
    // cycles land on every stage of the remainder and redraw loop.
    task automatic random_phase(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < n; j++)
            begin
                offer_item(pick_bound());
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       ;
                1:       pause_sender($urandom_range(1, 4));
                2:       pause_sender($urandom_range(5, 45));
                default: pause_sender(1);
            endcase
        end
    endtask

    logic [brx_pkg::WORD_W-1:0] directed_bounds [] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
        32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hC000_0001,
        32'h0000_0007, 32'h0000_0000, 32'h8000_0001, 32'h8000_0001,
        32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'h9999_999A
    };

    // Stimulus and verdict
    initial
    begin
        logic [brx_pkg::SEED_W-1:0] seeds [5];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items on the reset seed; the receiver is holding off here,
        // so the input queue fills and full must stall the sender.
        foreach (directed_bounds[i])
            offer_item(directed_bounds[i]);
        pause_sender(3);

        random_phase(PHASE_ITEMS);

        // Walk the seed through its extremes and a random value.
        seeds[0] = 64'd0;
        seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[2] = {$urandom(), $urandom()};
        seeds[3] = 64'h8000_0000_0000_0000;
        seeds[4] = 64'd1;
        foreach (seeds[k])
        begin
            write_seed(seeds[k]);
            random_phase(PHASE_ITEMS);
        end

        drain_block();
        repeat (50) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: a long hold-off right after reset, then random modes of
    // steady popping, coin-flip popping, rare popping and further long holds.
    initial
    begin
        int mode;
        int n;
        do @(posedge clk); while (!rst_n);
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 9);
            n = $urandom_range(10, 80);
            if (mode <= 3)
            begin
                repeat (n)
                begin
                    pop <= 1'b1;
                    @(posedge clk);
                end
            end
            else if (mode <= 6)
            begin
                repeat (n)
                begin
                    pop <= $urandom_range(0, 1);
                    @(posedge clk);
                end
            end
            else if (mode <= 8)
            begin
                repeat (n)
                begin
                    pop <= ($urandom_range(0, 5) == 0);
                    @(posedge clk);
                end
            end
            else
            begin
                pop <= 1'b0;
                repeat (200) @(posedge clk);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
